// ----- rtl/gdc_pkg.sv -----
// ----------------------------------------------------------------------------
// gdc_pkg: shared types and calendar helpers
// Date record, operation codes and the leap-year and month-length rules used
// by the Gregorian date counter.
// ----------------------------------------------------------------------------
package gdc_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;

  localparam logic [YearW-1:0]  BaseYear = 14'd1900;
  localparam logic [YearW-1:0]  MaxYear  = 14'd9999;
  localparam logic [MonthW-1:0] LastMonth = 4'd12;
  localparam logic [DayW-1:0]   LastDayDec = 5'd31;

  // Reciprocal of 100: (y * 5243) >> 19 equals y / 100 for every 14-bit y.
  localparam int unsigned Div100Mul   = 5243;
  localparam int unsigned Div100Shift = 19;
  localparam int unsigned ProdW       = YearW + 13;
  localparam int unsigned QuotW       = ProdW - Div100Shift;

  typedef enum logic [1:0] {
    OP_INC  = 2'd0,
    OP_DEC  = 2'd1,
    OP_LOAD = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } date_t;

  localparam date_t DefaultDate = '{year: BaseYear, month: 4'd1, day: 5'd1};

  // Gregorian rule: divisible by 4, centuries only when divisible by 400.
  function automatic logic leap_year(input logic [YearW-1:0] y);
    logic [ProdW-1:0] prod;
    logic [QuotW-1:0] quot;
    logic [YearW-1:0] hundreds;
    logic             century;
    prod     = {{(ProdW-YearW){1'b0}}, y} * ProdW'(Div100Mul);
    quot     = prod[ProdW-1:Div100Shift];
    hundreds = {{(YearW-QuotW){1'b0}}, quot} * YearW'(100);
    century  = (hundreds == y);
    return (y[1:0] == 2'b00) && (!century || (quot[1:0] == 2'b00));
  endfunction

  // Length of a month in 1..12; other codes give 31 and are never used.
  function automatic logic [DayW-1:0] month_length(input logic [MonthW-1:0] m,
                                                   input logic              leap);
    logic [DayW-1:0] len;
    unique case (m)
      4'd2:                   len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- rtl/gdc_date_step.sv -----
// ----------------------------------------------------------------------------
// gdc_date_step: one-operation date update
// Computes the date after a next-day, previous-day, load or no-change request,
// and whether a load request carried a valid date.
// ----------------------------------------------------------------------------
module gdc_date_step
  import gdc_pkg::*;
(
  input  date_t              cur_i,
  input  op_e                op_i,
  input  logic [DayW-1:0]    load_day_i,
  input  logic [MonthW-1:0]  load_month_i,
  input  logic [YearW-1:0]   load_year_i,
  output date_t              next_o,
  output logic               load_ok_o
);

  logic            cur_leap;
  logic [DayW-1:0] cur_len;
  logic [DayW-1:0] prev_len;
  logic            ld_leap;
  logic [DayW-1:0] ld_len;
  logic            ld_valid;
  date_t           inc_date;
  date_t           dec_date;

  // Month lengths for the current date, its previous month and the load date.
  assign cur_leap = leap_year(cur_i.year);
  assign cur_len  = month_length(cur_i.month, cur_leap);
  assign prev_len = month_length(cur_i.month - 4'd1, cur_leap);
  assign ld_leap  = leap_year(load_year_i);
  assign ld_len   = month_length(load_month_i, ld_leap);

  // A load is valid for a real month, a year in range and a day in the month.
  assign ld_valid = (load_month_i != '0) && (load_month_i <= LastMonth) &&
                    (load_year_i >= BaseYear) && (load_year_i <= MaxYear) &&
                    (load_day_i != '0) && (load_day_i <= ld_len);

  // Next day, rolling over month and year; the last representable date holds.
  always_comb begin
    inc_date = cur_i;
    if (cur_i.day < cur_len) begin
      inc_date.day = cur_i.day + 5'd1;
    end else if (cur_i.month < LastMonth) begin
      inc_date.day   = 5'd1;
      inc_date.month = cur_i.month + 4'd1;
    end else if (cur_i.year < MaxYear) begin
      inc_date.day   = 5'd1;
      inc_date.month = 4'd1;
      inc_date.year  = cur_i.year + 14'd1;
    end
  end

  // Previous day; stepping back from the first date lands on the first date.
  always_comb begin
    dec_date = DefaultDate;
    if (cur_i.day > 5'd1) begin
      dec_date      = cur_i;
      dec_date.day  = cur_i.day - 5'd1;
    end else if (cur_i.month > 4'd1) begin
      dec_date.year  = cur_i.year;
      dec_date.month = cur_i.month - 4'd1;
      dec_date.day   = prev_len;
    end else if (cur_i.year > BaseYear) begin
      dec_date.year  = cur_i.year - 14'd1;
      dec_date.month = LastMonth;
      dec_date.day   = LastDayDec;
    end
  end

  // Operation select.
  always_comb begin
    next_o    = cur_i;
    load_ok_o = 1'b0;
    unique case (op_i)
      OP_INC:  next_o = inc_date;
      OP_DEC:  next_o = dec_date;
      OP_LOAD: begin
        load_ok_o = ld_valid;
        if (ld_valid) begin
          next_o = '{year: load_year_i, month: load_month_i, day: load_day_i};
        end
      end
      OP_NOP:  next_o = cur_i;
      default: next_o = cur_i;
    endcase
  end

endmodule

// ----- rtl/gregorian_date_counter_unit.sv -----
// ----------------------------------------------------------------------------
// gregorian_date_counter_unit: Gregorian calendar day counter
// Holds a date and applies one next-day, previous-day, load or no-change
// request per cycle while the receiver does not stall, returning the date after each request.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis channel: tuser carries the operation
//   (0 next day, 1 previous day, 2 load, 3 no change) and tdata the date to
//   load. Every request yields exactly one response on m_axis: the date after
//   the request in tdata, and in tuser a load-accepted flag and a flag that
//   marks the first date 1/1/1900.
//   A request is first registered in the request register; its date update
//   runs from the request register to the response register, which offers
//   the response. Throughput is one request per cycle while the receiver does
//   not stall, since the date register is updated as each request moves on,
//   which also lets each request see the date left by the one just before it.
//   Reset sets the date to 1/1/1900 and empties both registers.
//   When the receiver stalls, the response register holds its contents and
//   one further request may still be taken into the request register; after
//   that s_axis_tready drops until m_axis_tready returns.
// ----------------------------------------------------------------------------
module gregorian_date_counter_unit
  import gdc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // load_day[4:0], load_month[8:5], load_year[22:9]
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  // Response channel.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // day_out[4:0], month_out[8:5], year_out[22:9]
  output logic [1:0]  m_axis_tuser    // load_ok[0], is_default[1]
);

  logic              req_valid_q;
  op_e               req_op_q;
  logic [DayW-1:0]   req_day_q;
  logic [MonthW-1:0] req_month_q;
  logic [YearW-1:0]  req_year_q;

  date_t             date_q, date_d;
  logic              load_ok_d;

  logic              rsp_valid_q;
  date_t             rsp_date_q;
  logic              rsp_load_ok_q;
  logic              rsp_default_q;

  logic              advance;
  logic              req_take;
  logic [DayW-1:0]   date_len;

  // The request moves on whenever the response register is free or drained.
  assign advance       = req_valid_q && (!rsp_valid_q || m_axis_tready);
  assign s_axis_tready = !req_valid_q || advance;
  assign req_take      = s_axis_tvalid && s_axis_tready;

  // Request register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      req_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_take) begin
      req_op_q    <= op_e'(s_axis_tuser);
      req_day_q   <= s_axis_tdata[4:0];
      req_month_q <= s_axis_tdata[8:5];
      req_year_q  <= s_axis_tdata[22:9];
    end
  end

  // Date update.
  gdc_date_step u_step (
    .cur_i        (date_q),
    .op_i         (req_op_q),
    .load_day_i   (req_day_q),
    .load_month_i (req_month_q),
    .load_year_i  (req_year_q),
    .next_o       (date_d),
    .load_ok_o    (load_ok_d)
  );

  // Current date register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      date_q <= DefaultDate;
    end else if (advance) begin
      date_q <= date_d;
    end
  end

  // Response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (advance) begin
      rsp_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_date_q    <= date_d;
      rsp_load_ok_q <= load_ok_d;
      rsp_default_q <= (date_d == DefaultDate);
    end
  end

  assign m_axis_tvalid = rsp_valid_q;
  assign m_axis_tdata  = {1'b0, rsp_date_q.year, rsp_date_q.month, rsp_date_q.day};
  assign m_axis_tuser  = {rsp_default_q, rsp_load_ok_q};

  // Length of the current month, for checking the stored date.
  assign date_len = month_length(date_q.month, leap_year(date_q.year));

  // The stored date is always a real calendar date in range.
  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (date_q.day != '0) && (date_q.day <= date_len) &&
    (date_q.month != '0) && (date_q.month <= LastMonth) &&
    (date_q.year >= BaseYear) && (date_q.year <= MaxYear))
    else $error("stored date out of range");

  // The date changes only when a request moves into the response register.
  a_date_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(date_q))
    else $error("date changed without a request");

  // A response always reports the date held after its request.
  a_rsp_matches_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (rsp_date_q == date_q))
    else $error("response date differs from stored date");

  // The first-date flag agrees with the reported date.
  a_default_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> (rsp_default_q == (rsp_date_q == DefaultDate)))
    else $error("first-date flag inconsistent");

  // A load accepted flag only follows a load request.
  a_load_ok_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (req_op_q != OP_LOAD)) |=> !rsp_load_ok_q)
    else $error("load flag set for a non-load request");

endmodule

// ----- verif/gdc_response_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdc_response_checker: response checker for the Gregorian date counter
// Watches both stream channels of the counter, keeps its own copy of the
// calendar date, works out the response each accepted request must produce
// and compares every accepted response field by field, in order.
// ----------------------------------------------------------------------------
module gdc_response_checker
  import gdc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel, observed only.
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // load_day[4:0], load_month[8:5], load_year[22:9]
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  // Response channel, observed only.
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,   // day_out[4:0], month_out[8:5], year_out[22:9]
  input  logic [1:0]  m_axis_tuser,   // load_ok[0], is_default[1]
  // Results handed to the testbench top.
  output int          mismatch_count_o,
  output int          pending_o,
  output int          checked_o,
  output int          loads_taken_o
);

  typedef struct packed {
    date_t date;
    logic  load_ok;
    logic  is_default;
  } date_resp_t;

  // Calendar date as the counter should hold it.
  date_t      cal_date;
  // Responses still owed by the counter, oldest first.
  date_resp_t date_resp_q[$];

  function automatic logic is_leap(input logic [YearW-1:0] y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic logic [DayW-1:0] days_in_month(input logic [MonthW-1:0] m,
                                                    input logic [YearW-1:0]  y);
    case (m)
      4'd2:                    return is_leap(y) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
      default:                 return 5'd31;
    endcase
  endfunction

  // Applies one request to the calendar date and returns the response it owes.
  function automatic date_resp_t apply_request(input op_e op, input date_t ld);
    date_resp_t resp;
    logic       ok;
    ok = 1'b0;
    case (op)
      OP_INC: begin
        if (cal_date.day < days_in_month(cal_date.month, cal_date.year)) begin
          cal_date.day = cal_date.day + 1'b1;
        end else if (cal_date.month < LastMonth) begin
          cal_date.day   = 5'd1;
          cal_date.month = cal_date.month + 1'b1;
        end else if (cal_date.year < MaxYear) begin
          cal_date.day   = 5'd1;
          cal_date.month = 4'd1;
          cal_date.year  = cal_date.year + 1'b1;
        end
        // The last representable day holds.
      end
      OP_DEC: begin
        if (cal_date.day > 5'd1) begin
          cal_date.day = cal_date.day - 1'b1;
        end else if (cal_date.month > 4'd1) begin
          cal_date.month = cal_date.month - 1'b1;
          cal_date.day   = days_in_month(cal_date.month, cal_date.year);
        end else if (cal_date.year > BaseYear) begin
          cal_date.month = LastMonth;
          cal_date.day   = LastDayDec;
          cal_date.year  = cal_date.year - 1'b1;
        end else begin
          // Stepping back from the first date falls back to it.
          cal_date = DefaultDate;
        end
      end
      OP_LOAD: begin
        if (ld.month >= 4'd1 && ld.month <= LastMonth &&
            ld.year >= BaseYear && ld.year <= MaxYear &&
            ld.day >= 5'd1 && ld.day <= days_in_month(ld.month, ld.year)) begin
          cal_date = ld;
          ok       = 1'b1;
        end
      end
      default: ;
    endcase
    resp.date       = cal_date;
    resp.load_ok    = ok;
    resp.is_default = (cal_date == DefaultDate);
    return resp;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count_o++;
    end
  endtask

  // Responses are checked before the request of the same edge is predicted,
  // since no response can belong to a request taken at that very edge.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    date_resp_t got;
    date_resp_t want;
    if (!rst_ni) begin
      cal_date = DefaultDate;
      date_resp_q.delete();
      pending_o        = 0;
      mismatch_count_o = 0;
      checked_o        = 0;
      loads_taken_o    = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        // The date record packs exactly like the low 23 bits of tdata.
        got.date       = date_t'(m_axis_tdata[22:0]);
        got.load_ok    = m_axis_tuser[0];
        got.is_default = m_axis_tuser[1];
        if (date_resp_q.size() == 0) begin
          $display("%0t ns: unexpected response, expected none, actual %0d/%0d/%0d",
                   $time, got.date.day, got.date.month, got.date.year);
          mismatch_count_o++;
        end else begin
          want = date_resp_q.pop_front();
          compare_field("day", want.date.day, got.date.day);
          compare_field("month", want.date.month, got.date.month);
          compare_field("year", want.date.year, got.date.year);
          compare_field("load_ok", want.load_ok, got.load_ok);
          compare_field("is_default", want.is_default, got.is_default);
          checked_o++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = apply_request(op_e'(s_axis_tuser), date_t'(s_axis_tdata[22:0]));
        if (want.load_ok) begin
          loads_taken_o++;
        end
        date_resp_q.push_back(want);
      end
      pending_o = date_resp_q.size();
    end
  end

endmodule

// ----- verif/gregorian_date_counter_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_counter_unit_test: testbench for the Gregorian date counter
// Sends directed and random next-day, previous-day, load and no-change
// requests under three pacing phases and two long output stalls, while a
// separate checker predicts and compares every response.
// ----------------------------------------------------------------------------
module gregorian_date_counter_unit_test
  import gdc_pkg::*;
();

  localparam int unsigned    HalfPeriodNs  = 6;
  localparam int unsigned    ResetCycles   = 5;
  localparam int unsigned    HoldOffCycles = 300;
  localparam int unsigned    ItemsPerPhase = 630;
  localparam int unsigned    DrainCycles   = 8;
  localparam longint unsigned TimeoutNs    = 5_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  int          mismatch_count;
  int          pending;
  int          checked;
  int          loads_taken;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned requests_sent;
  int unsigned hold_off_asks;

  gregorian_date_counter_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  gdc_response_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending),
    .checked_o        (checked),
    .loads_taken_o    (loads_taken)
  );

  // 12 ns clock.
  always begin
    clk_i = 1'b0;
    #(HalfPeriodNs);
    clk_i = 1'b1;
    #(HalfPeriodNs);
  end

  // Hard stop in case the counter hangs.
  initial begin
    #(TimeoutNs);
    $display("Regression FAIL");
    $finish;
  end

  // Response side: random back-pressure, plus a long hold-off on request.
  initial begin : receiver
    int unsigned seen;
    seen = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_asks != seen) begin
        seen = hold_off_asks;
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Offers one request, with random idle cycles first; returns at a falling edge.
  task automatic send_date_request(input op_e op, input logic [4:0] d,
                                   input logic [3:0] m, input logic [13:0] y);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, y, m, d};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    requests_sent++;
    @(negedge clk_i);
  endtask

  // Request whose date fields are random over their full width.
  task automatic send_random_fields(input op_e op);
    send_date_request(op, 5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
                      14'($urandom_range(0, 16383)));
  endtask

  // Load of a mostly valid date, biased to month and year boundaries.
  task automatic send_calendar_load();
    logic [13:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    case ($urandom_range(0, 5))
      0:       y = BaseYear;
      1:       y = 14'd2000;
      2:       y = 14'd2100;
      3:       y = MaxYear;
      4:       y = BaseYear + 14'($urandom_range(0, 200));
      default: y = 14'($urandom_range(BaseYear, MaxYear));
    endcase
    case ($urandom_range(0, 5))
      0:       m = 4'd1;
      1:       m = 4'd2;
      2:       m = LastMonth;
      default: m = 4'($urandom_range(1, 12));
    endcase
    // Half inside every month, half around the month end.
    d = $urandom_range(0, 1) ? 5'($urandom_range(1, 28)) : 5'($urandom_range(28, 31));
    send_date_request(OP_LOAD, d, m, y);
  endtask

  // Mostly a load followed by a run of day steps; sometimes pure noise.
  task automatic run_random_episode();
    int unsigned steps;
    op_e         dir;
    op_e         op;
    if ($urandom_range(0, 9) == 0) begin
      steps = $urandom_range(1, 8);
      repeat (steps) send_random_fields(op_e'($urandom_range(0, 3)));
    end else begin
      send_calendar_load();
      dir   = $urandom_range(0, 1) ? OP_INC : OP_DEC;
      steps = $urandom_range(1, 30);
      repeat (steps) begin
        case ($urandom_range(0, 19))
          0:       op = OP_NOP;
          1, 2:    op = (dir == OP_INC) ? OP_DEC : OP_INC;
          default: op = dir;
        endcase
        send_random_fields(op);
      end
    end
  endtask

  // Stops offering and waits for every owed response.
  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned phase_start;
    bit          asked;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_INC;
    send_idle_pct = 20;
    recv_idle_pct = 60;
    requests_sent = 0;
    hold_off_asks = 0;
    // Count rising edges so the first clock transition cannot shorten reset.
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: first date, ignored fields, leap rules, boundaries, bad loads.
    send_date_request(OP_DEC, 5'd0, 4'd0, 14'd0);
    send_date_request(OP_NOP, 5'd31, 4'd15, 14'd16383);
    send_date_request(OP_INC, 5'd31, 4'd15, 14'd16383);
    send_date_request(OP_DEC, 5'd31, 4'd15, 14'd16383);
    send_date_request(OP_LOAD, 5'd29, 4'd2, 14'd1900);
    send_date_request(OP_LOAD, 5'd28, 4'd2, 14'd2100);
    send_date_request(OP_INC, 5'd0, 4'd0, 14'd0);
    send_date_request(OP_LOAD, 5'd29, 4'd2, 14'd2000);
    send_date_request(OP_INC, 5'd0, 4'd0, 14'd0);
    send_date_request(OP_DEC, 5'd0, 4'd0, 14'd0);
    send_date_request(OP_LOAD, 5'd1, 4'd3, 14'd2024);
    send_date_request(OP_DEC, 5'd0, 4'd0, 14'd0);
    send_date_request(OP_LOAD, 5'd31, 4'd12, MaxYear);
    send_date_request(OP_INC, 5'd0, 4'd0, 14'd0);
    send_date_request(OP_DEC, 5'd0, 4'd0, 14'd0);
    send_date_request(OP_LOAD, 5'd31, 4'd4, 14'd2023);
    send_date_request(OP_LOAD, 5'd0, 4'd5, 14'd2023);
    send_date_request(OP_LOAD, 5'd15, 4'd0, 14'd2023);
    send_date_request(OP_LOAD, 5'd15, 4'd13, 14'd2023);
    send_date_request(OP_LOAD, 5'd15, 4'd15, 14'd2023);
    send_date_request(OP_LOAD, 5'd1, 4'd1, 14'd1899);
    send_date_request(OP_LOAD, 5'd1, 4'd1, 14'd10000);
    send_date_request(OP_LOAD, 5'd31, 4'd12, 14'd16383);
    send_date_request(OP_LOAD, 5'd1, 4'd1, 14'd0);
    send_date_request(OP_LOAD, 5'd31, 4'd12, BaseYear);
    send_date_request(OP_INC, 5'd0, 4'd0, 14'd0);
    send_date_request(OP_DEC, 5'd0, 4'd0, 14'd0);
    send_date_request(OP_LOAD, 5'd1, 4'd1, BaseYear);
    pause_until_drained();

    // Random: slow receiver, then slow sender, then full rate.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 20; recv_idle_pct = 60; end
        1:       begin send_idle_pct = 60; recv_idle_pct = 20; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      phase_start = requests_sent;
      asked       = 1'b0;
      while (requests_sent < phase_start + ItemsPerPhase) begin
        // A long output stall while the sender keeps offering.
        if (phase != 1 && !asked && requests_sent >= phase_start + 200) begin
          hold_off_asks++;
          asked = 1'b1;
        end
        run_random_episode();
      end
      pause_until_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    $display("Covered %0d requests (%0d loads accepted) over three pacing phases", requests_sent,
             loads_taken);
    $display("and two long output stalls; %0d responses compared field by field.", checked);
    if (mismatch_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/gdc_pkg.sv
rtl/gdc_date_step.sv
rtl/gregorian_date_counter_unit.sv
verif/gdc_response_checker.sv
verif/gregorian_date_counter_unit_test.sv
